// File: sv/bdc_pkg.sv
// bdc_pkg: shared constants and types of the box clustering block
// no dependencies
package bdc_pkg;
  localparam int MaxBoxes = 64;
  localparam int CoordBits = 12;
  localparam int IdxW = $clog2(MaxBoxes);
  localparam int CntW = $clog2(MaxBoxes + 1);
  localparam int BoxW = 4 * CoordBits;
  localparam int LabelW = 7;
  localparam int GapW = ((CoordBits > 12) ? CoordBits : 12) + 2;

  localparam logic [1:0] REG_EPSILON = 2'd0;
  localparam logic [1:0] REG_MIN_POINTS = 2'd1;

  typedef logic [CoordBits-1:0] coord_t;
  typedef struct packed {
    coord_t l;
    coord_t r;
    coord_t t;
    coord_t b;
  } box_t;

  // neighbour test: full overlap, or vertical overlap with gap within epsilon
  function automatic logic is_neighbour(box_t c, box_t o, logic [11:0] eps);
    logic h, v;
    logic signed [GapW-1:0] d1, d2, gap;
    h = (c.r >= o.l && o.l >= c.l) || (o.r >= c.l && c.l >= o.l);
    v = (c.b >= o.t && o.t >= c.t) || (o.b >= c.t && c.t >= o.t);
    d1 = $signed(GapW'(o.l)) - $signed(GapW'(c.r));
    d2 = $signed(GapW'(c.l)) - $signed(GapW'(o.r));
    gap = (d1 > d2) ? d1 : d2;
    return (h && v) || (v && (gap <= $signed(GapW'(eps))));
  endfunction
endpackage

// File: sv/bdc_ram.sv
// bdc_ram: generic single write port, single registered read port memory
// no dependencies
module bdc_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: sv/box_dbscan_clusterer.sv
// box_dbscan_clusterer: loads boxes, then clusters them with dbscan; uses bdc_pkg, bdc_ram
// sequence: a non-final item is stored; the final item starts a label clear of the stored
// boxes, then the walk of core tests and seed expansions
// throughput: one box per cycle while loading; busy stays high over the walk, the
// shared neighbour unit compares one box pair at a time, labels follow 1 per cycle
// reset: synchronous active high; registers return to 10 and 2, store empty
module box_dbscan_clusterer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  logic [11:0]           box_left,
  input  logic [11:0]           box_right,
  input  logic [11:0]           box_top,
  input  logic [11:0]           box_bottom,
  input  logic                  final_box,
  output logic                  result_valid,
  output logic [5:0]            box_index,
  output logic [6:0]            cluster_label,
  output logic                  overflow,
  output logic                  end_of_labels
);
  import bdc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0, S_CLEAR = 5'd1, S_NEXT = 5'd2, S_CHK = 5'd3,
    S_GATH = 5'd4, S_GCMP = 5'd5, S_LRD = 5'd6, S_LWR = 5'd7, S_DRP0 = 5'd8,
    S_SHRD = 5'd9, S_SHWR = 5'd10, S_SEED = 5'd11, S_SLD = 5'd12, S_SBOX = 5'd13,
    S_XGATH = 5'd14, S_XCMP = 5'd15, S_ORD = 5'd16, S_OUT = 5'd17;

  logic [4:0] state;
  logic [11:0] epsilon;
  logic [6:0] min_points;
  logic [CntW-1:0] box_count;
  logic overflow_flag;
  logic [LabelW-1:0] next_cluster;

  // walk registers
  logic [CntW-1:0] core_i;     // outer loop box, also clear and output index
  logic [CntW-1:0] scan_j;     // gather scan index
  logic [CntW-1:0] nbr_cnt;    // neighbours found by scan
  logic [CntW-1:0] qlen;       // seed queue length
  logic [CntW-1:0] qpos;       // current seed position
  logic [CntW-1:0] drop;       // queue slot of the last copy of the core box
  logic first_pass;            // gather for the core box itself
  box_t centre;

  // box store
  logic box_we;
  logic [IdxW-1:0] box_waddr, box_raddr;
  box_t box_rdata;
  bdc_ram #(.Width(BoxW), .Depth(MaxBoxes)) u_boxes (
    .clk(clk), .we(box_we), .waddr(box_waddr), .wdata({box_left[CoordBits-1:0],
    box_right[CoordBits-1:0], box_top[CoordBits-1:0], box_bottom[CoordBits-1:0]}),
    .raddr(box_raddr), .rdata(box_rdata));

  // seed queue
  logic q_we;
  logic [IdxW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;
  bdc_ram #(.Width(IdxW), .Depth(MaxBoxes)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata));

  // label store, cleared over the stored boxes before each walk
  logic lab_we;
  logic [IdxW-1:0] lab_waddr, lab_raddr;
  logic [LabelW-1:0] lab_wdata, lab_rdata;
  bdc_ram #(.Width(LabelW), .Depth(MaxBoxes)) u_labels (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rdata));

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_POINTS[0]) ? {25'd0, min_points} : {20'd0, epsilon};

  // shared neighbour unit
  logic nb_hit;
  assign nb_hit = is_neighbour(centre, box_rdata, epsilon);
  logic same_box;
  assign same_box = (box_rdata == centre);
  // core test: too few neighbours, itself included
  logic few_nbrs;
  assign few_nbrs = (8'(nbr_cnt) < {1'b0, min_points});

  assign box_we = accept && (box_count < CntW'(MaxBoxes));
  assign box_waddr = box_count[IdxW-1:0];

  always_comb begin
    box_raddr = scan_j[IdxW-1:0];
    q_raddr = qpos[IdxW-1:0];
    lab_raddr = scan_j[IdxW-1:0];
    q_we = 1'b0;
    q_waddr = '0;
    q_wdata = '0;
    lab_we = 1'b0;
    lab_waddr = '0;
    lab_wdata = '0;
    case (state)
      S_CLEAR: begin
        lab_we = (core_i < box_count); lab_waddr = core_i[IdxW-1:0];
      end
      S_NEXT: begin
        box_raddr = core_i[IdxW-1:0]; lab_raddr = core_i[IdxW-1:0];
      end
      S_GCMP: begin
        if (nb_hit && first_pass) begin
          q_we = 1'b1; q_waddr = nbr_cnt[IdxW-1:0]; q_wdata = scan_j[IdxW-1:0];
        end
      end
      S_LWR: begin
        lab_we = 1'b1; lab_waddr = q_rdata; lab_wdata = next_cluster;
      end
      S_SHRD: q_raddr = IdxW'(qpos + 1'b1);
      S_SHWR: begin
        q_we = 1'b1; q_waddr = qpos[IdxW-1:0]; q_wdata = q_rdata;
      end
      S_SLD: box_raddr = q_rdata;
      S_XCMP: begin
        if (nb_hit && lab_rdata == '0) begin
          lab_we = 1'b1; lab_waddr = scan_j[IdxW-1:0]; lab_wdata = next_cluster;
          if (qlen < CntW'(MaxBoxes)) begin
            q_we = 1'b1; q_waddr = qlen[IdxW-1:0]; q_wdata = scan_j[IdxW-1:0];
          end
        end
      end
      S_ORD: lab_raddr = core_i[IdxW-1:0];
      S_OUT: lab_raddr = IdxW'(core_i + 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      epsilon <= 12'd10;
      min_points <= 7'd2;
      box_count <= '0;
      overflow_flag <= 1'b0;
      next_cluster <= 7'd1;
      result_valid <= 1'b0;
      box_index <= '0;
      cluster_label <= '0;
      overflow <= 1'b0;
      end_of_labels <= 1'b0;
      core_i <= '0;
      scan_j <= '0;
      nbr_cnt <= '0;
      qlen <= '0;
      qpos <= '0;
      drop <= '0;
      first_pass <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_EPSILON[0]) epsilon <= pwdata[11:0];
        else min_points <= pwdata[6:0];
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (box_count < CntW'(MaxBoxes)) box_count <= box_count + 1'b1;
            else overflow_flag <= 1'b1;
            if (final_box) begin
              next_cluster <= 7'd1;
              core_i <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (core_i >= box_count) begin
            core_i <= '0; state <= S_NEXT;
          end else core_i <= core_i + 1'b1;
        end
        S_NEXT: begin
          if (core_i >= box_count) begin
            core_i <= '0;
            state <= S_ORD;
          end else state <= S_CHK;  // box and label reads in flight
        end
        S_CHK: begin
          if (lab_rdata != '0) begin
            core_i <= core_i + 1'b1; state <= S_NEXT;
          end else begin
            centre <= box_rdata;
            first_pass <= 1'b1;
            scan_j <= '0; nbr_cnt <= '0; drop <= '0;
            state <= S_GATH;
          end
        end
        S_GATH: begin
          if (scan_j >= box_count) begin
            if (first_pass) begin
              if (few_nbrs) begin
                core_i <= core_i + 1'b1; state <= S_NEXT;
              end else begin
                qlen <= nbr_cnt; qpos <= '0; state <= S_LRD;
              end
            end else if (few_nbrs) begin
              qpos <= qpos + 1'b1; state <= S_SEED;
            end else begin
              scan_j <= '0; state <= S_XGATH;
            end
          end else state <= S_GCMP;
        end
        S_GCMP: begin
          scan_j <= scan_j + 1'b1;
          state <= S_GATH;
          if (nb_hit) begin
            nbr_cnt <= nbr_cnt + 1'b1;
            if (first_pass && same_box) drop <= nbr_cnt;
          end
        end
        // every initial neighbour of the core box takes the new label
        S_LRD: state <= (qpos >= qlen) ? S_DRP0 : S_LWR;
        S_LWR: begin
          qpos <= qpos + 1'b1; state <= S_LRD;
        end
        // remove the core box copy from the work list
        S_DRP0: begin
          if (qlen == '0) begin
            qpos <= '0; state <= S_SEED;
          end else begin
            qpos <= drop; state <= S_SHRD;
          end
        end
        S_SHRD: begin
          if (qpos + 1'b1 >= qlen) begin
            qlen <= qlen - 1'b1; qpos <= '0; state <= S_SEED;
          end else state <= S_SHWR;
        end
        S_SHWR: begin
          qpos <= qpos + 1'b1; state <= S_SHRD;
        end
        S_SEED: begin
          if (qpos >= qlen) begin
            next_cluster <= next_cluster + 1'b1;
            core_i <= core_i + 1'b1; state <= S_NEXT;
          end else state <= S_SLD;
        end
        S_SLD: state <= S_SBOX;  // seed box read in flight
        S_SBOX: begin
          centre <= box_rdata;
          first_pass <= 1'b0;
          scan_j <= '0; nbr_cnt <= '0;
          state <= S_GATH;
        end
        S_XGATH: begin
          if (scan_j >= box_count) begin
            qpos <= qpos + 1'b1; state <= S_SEED;
          end else state <= S_XCMP;
        end
        S_XCMP: begin
          scan_j <= scan_j + 1'b1;
          state <= S_XGATH;
          if (nb_hit && lab_rdata == '0 && qlen < CntW'(MaxBoxes)) qlen <= qlen + 1'b1;
        end
        S_ORD: state <= S_OUT;  // first label read in flight
        S_OUT: begin
          result_valid <= 1'b1;
          box_index <= core_i[IdxW-1:0];
          cluster_label <= lab_rdata;
          overflow <= overflow_flag;
          end_of_labels <= (core_i + 1'b1 == box_count);
          core_i <= core_i + 1'b1;
          if (core_i + 1'b1 >= box_count) begin
            box_count <= '0; overflow_flag <= 1'b0; next_cluster <= 7'd1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == S_OUT) else $error("result outside output phase");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    box_count <= CntW'(MaxBoxes)) else $error("box count beyond capacity");
  a_busy_walk: assert property (@(posedge clk) disable iff (rst)
    (accept && final_box) |=> busy) else $error("walk not started");
`endif
endmodule

// File: tb/box_dbscan_clusterer_tb.sv
// box_dbscan_clusterer_tb: self-checking bench for the box clustering block
// depends on bdc_pkg and the box_dbscan_clusterer rtl
// box sets are loaded, clustered by an in-bench predictor and every label is checked
module box_dbscan_clusterer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdc_pkg::*;

  localparam int WatchdogLimit = 4000000;

  typedef struct {
    logic [5:0] idx;
    logic [6:0] label;
    logic       ovf;
    logic       last;
  } label_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] box_left = '0, box_right = '0, box_top = '0, box_bottom = '0;
  logic        final_box = 1'b0;
  logic        result_valid;
  logic [5:0]  box_index;
  logic [6:0]  cluster_label;
  logic        overflow;
  logic        end_of_labels;

  box_dbscan_clusterer uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  box_t        set_boxes[MaxBoxes];
  int          set_count;
  logic        set_dropped;
  logic [11:0] eps_shadow;
  logic [6:0]  minpts_shadow;
  label_t      label_queue[$];

  int  mismatches;
  int  idle_pct;
  int  stall_cycles;

  // neighbour rule written out with plain integers
  function automatic bit boxes_touch(box_t c, box_t o);
    int cl, cr, ct, cb, ol, orr, ot, ob, g;
    bit h, v;
    cl = c.l; cr = c.r; ct = c.t; cb = c.b;
    ol = o.l; orr = o.r; ot = o.t; ob = o.b;
    h = (cr >= ol && ol >= cl) || (orr >= cl && cl >= ol);
    v = (cb >= ot && ot >= ct) || (ob >= ct && ct >= ot);
    if (h && v) return 1;
    if (!v) return 0;
    g = (ol - cr) > (cl - orr) ? (ol - cr) : (cl - orr);
    return g <= int'(eps_shadow);
  endfunction

  function automatic int collect_neighbours(int p, ref int lst[MaxBoxes]);
    int n;
    n = 0;
    for (int i = 0; i < set_count; i++)
      if (boxes_touch(set_boxes[p], set_boxes[i])) begin
        lst[n] = i;
        n++;
      end
    return n;
  endfunction

  // cluster the stored set and queue one label per stored box
  function automatic void cluster_set();
    int labels[MaxBoxes];
    int seeds[MaxBoxes];
    int nb[MaxBoxes];
    int cid, n, m, drop, qlen, x;
    cid = 1;
    foreach (labels[i]) labels[i] = 0;
    for (int c = 0; c < set_count; c++) begin
      if (labels[c] != 0) continue;
      n = collect_neighbours(c, seeds);
      if (n < int'(minpts_shadow)) continue;
      drop = 0;
      for (int i = 0; i < n; i++) begin
        labels[seeds[i]] = cid;
        if (set_boxes[seeds[i]] == set_boxes[c]) drop = i;
      end
      qlen = n;
      if (qlen > 0) begin
        for (int i = drop; i + 1 < qlen; i++) seeds[i] = seeds[i+1];
        qlen--;
      end
      for (int i = 0; i < qlen; i++) begin
        m = collect_neighbours(seeds[i], nb);
        if (m < int'(minpts_shadow)) continue;
        for (int k = 0; k < m; k++) begin
          x = nb[k];
          if (labels[x] == 0) begin
            if (qlen < MaxBoxes) begin
              seeds[qlen] = x;
              qlen++;
            end
            labels[x] = cid;
          end
        end
      end
      cid = (cid + 1) & 7'h7f;
    end
    for (int i = 0; i < set_count; i++)
      label_queue.insert(label_queue.size(), '{idx: i[5:0], label: labels[i][6:0],
                         ovf: set_dropped, last: (i + 1 == set_count)});
    set_count = 0;
    set_dropped = 0;
  endfunction

  // result checker; the block cannot be held off so every strobe is taken
  always @(posedge clk) begin
    label_t e;
    if (!rst && result_valid) begin
      if (label_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected label for box %0d", box_index);
      end else begin
        e = label_queue.pop_front();
        if (e.idx !== box_index || e.label !== cluster_label || e.ovf !== overflow ||
            e.last !== end_of_labels) begin
          mismatches++;
          if (mismatches <= 10)
            $display("label mismatch: exp idx %0d lbl %0d ovf %0b end %0b, got %0d %0d %0b %0b",
                     e.idx, e.label, e.ovf, e.last, box_index, cluster_label, overflow,
                     end_of_labels);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || result_valid || (start && !busy) || (psel && penable)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // register write over the config port, only while idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_EPSILON) eps_shadow = val[11:0];
    else if (idx == REG_MIN_POINTS) minpts_shadow = val[6:0];
  endtask

  // stop sending, wait for every label, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (label_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // send one box item; start stays high across back-to-back items
  task automatic send_box(input box_t b, input bit fin);
    while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    box_left <= b.l; box_right <= b.r; box_top <= b.t; box_bottom <= b.b;
    final_box <= fin;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (set_count < MaxBoxes) begin
      set_boxes[set_count] = b;
      set_count++;
    end else begin
      set_dropped = 1;
    end
    if (fin) cluster_set();
  endtask

  function automatic box_t near_box(int cx, int cy);
    box_t b;
    int w, h;
    w = $urandom_range(30, 0);
    h = $urandom_range(30, 0);
    b.l = 12'(cx + $urandom_range(40, 0));
    b.t = 12'(cy + $urandom_range(40, 0));
    b.r = 12'(b.l + w);
    b.b = 12'(b.t + h);
    return b;
  endfunction

  // directed: extremes, duplicates, inverted boxes, single-box set
  task automatic test_directed();
    send_box('{l: 12'd0, r: 12'd0, t: 12'd0, b: 12'd0}, 1);
    send_box('{l: 12'hfff, r: 12'hfff, t: 12'hfff, b: 12'hfff}, 0);
    send_box('{l: 12'd0, r: 12'hfff, t: 12'd0, b: 12'hfff}, 0);
    send_box('{l: 12'd100, r: 12'd110, t: 12'd0, b: 12'd20}, 0);
    send_box('{l: 12'd100, r: 12'd110, t: 12'd0, b: 12'd20}, 0);
    send_box('{l: 12'd121, r: 12'd130, t: 12'd5, b: 12'd9}, 0);
    send_box('{l: 12'd500, r: 12'd400, t: 12'd300, b: 12'd200}, 0);
    send_box('{l: 12'd2000, r: 12'd2010, t: 12'd3000, b: 12'd3010}, 1);
    drain();
    write_reg(REG_MIN_POINTS, 32'd0);
    write_reg(REG_EPSILON, 32'd0);
    send_box('{l: 12'd10, r: 12'd20, t: 12'd10, b: 12'd20}, 0);
    send_box('{l: 12'd21, r: 12'd30, t: 12'd10, b: 12'd20}, 0);
    send_box('{l: 12'd20, r: 12'd30, t: 12'd10, b: 12'd20}, 1);
    drain();
  endtask

  // store overflow: more than capacity, the dropped box carries the final mark
  task automatic test_overflow();
    write_reg(REG_EPSILON, 32'hffff_ffff);
    write_reg(REG_MIN_POINTS, 32'd64);
    for (int i = 0; i < MaxBoxes + 2; i++)
      send_box(near_box(0, 0), i == MaxBoxes + 1);
    drain();
  endtask

  // random sets: mostly clustered boxes, some scattered noise
  task automatic test_random(input int n_items);
    int left, sz, cx, cy;
    box_t b;
    left = n_items;
    while (left > 0) begin
      sz = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(12, 1);
      if (sz > left) sz = left;
      cx = $urandom_range(4000, 0);
      cy = $urandom_range(4000, 0);
      for (int i = 0; i < sz; i++) begin
        if ($urandom_range(4, 0) == 0) begin
          b.l = 12'($urandom()); b.r = 12'($urandom());
          b.t = 12'($urandom()); b.b = 12'($urandom());
        end else b = near_box(cx, cy);
        send_box(b, i == sz - 1);
      end
      left -= sz;
    end
  endtask

  initial begin
    mismatches = 0;
    idle_pct = 24;
    set_count = 0;
    set_dropped = 0;
    eps_shadow = 12'd10;
    minpts_shadow = 7'd2;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    write_reg(REG_EPSILON, 32'd10);
    write_reg(REG_MIN_POINTS, 32'd2);
    test_random(30);
    drain();
    // sender hold-off until every label is in, then a new setting
    idle_pct = 79;
    write_reg(REG_EPSILON, 32'd40);
    write_reg(REG_MIN_POINTS, 32'd3);
    test_random(30);
    drain();
    idle_pct = 0;
    write_reg(REG_EPSILON, 32'd4095);
    write_reg(REG_MIN_POINTS, 32'd1);
    test_random(30);
    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
